// ===== rtl/fbsz_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the frame blit block
// used by fbsz_ctrl, fbsz_dp and frame_blit_scroll_zoom_fade_top
package fbsz_pkg;

  // default frame store size
  localparam int unsigned MAX_WIDTH_DEF  = 128;
  localparam int unsigned MAX_HEIGHT_DEF = 64;

  // coordinate register width: largest zoomed coordinate is 255*32767>>12
  localparam int unsigned CW = 11;
  // zoom reciprocal fraction bits (Q3.12)
  localparam int unsigned ZFRAC = 12;
  // bit-serial remainder: numerator width and step counter width
  localparam int unsigned MOD_BITS = 9;
  localparam int unsigned CNT_W    = $clog2(MOD_BITS);

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 15;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCROLL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ZINV   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ZOFF   = 3'd6;

  // render modes
  localparam logic [1:0] MODE_COPY   = 2'd0;
  localparam logic [1:0] MODE_FADE   = 2'd1;
  localparam logic [1:0] MODE_SCROLL = 2'd2;
  localparam logic [1:0] MODE_ZOOM   = 2'd3;

  // item function
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_RENDER = 1'b1;

  // unity alpha in Q1.8
  localparam logic [8:0] ALPHA_ONE = 9'd256;

  typedef struct packed {
    logic capture;   // take a new item
    logic mod_step;  // one remainder step on both lanes
    logic mul_x;     // multiply shifted column by zoom reciprocal
    logic mul_y;     // keep column, multiply row
    logic zoom_fin;  // keep row
    logic check;     // bounds check and store address
    logic write;     // write frame store
    logic read;      // read frame store
    logic emit;      // load result registers
  } fbsz_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       mod_last;
  } fbsz_status_t;

endpackage

// ===== rtl/fbsz_ctrl.sv =====
`timescale 1ns / 1ps
// sequencer of the frame blit block: one item at a time through its steps
// depends on fbsz_pkg
module fbsz_ctrl
  import fbsz_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start,
  input  logic         func_i,
  input  fbsz_status_t status_i,
  output fbsz_cmd_t    cmd_o,
  output logic         busy_o,
  output logic         done_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MOD,
    S_MULX,
    S_MULY,
    S_ZFIN,
    S_CHK,
    S_STORE,
    S_READ,
    S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   ld_q, ld_d;
  logic   busy_q;
  logic   done_q;
  logic   accept;

  assign accept = start & ~busy_q;

  always_comb begin
    state_d = state_q;
    ld_d    = ld_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          ld_d = (func_i == FUNC_LOAD);
          if (func_i == FUNC_LOAD) begin
            state_d = S_CHK;
          end else begin
            case (status_i.mode)
              MODE_SCROLL: state_d = S_MOD;
              MODE_ZOOM:   state_d = S_MULX;
              default:     state_d = S_CHK;
            endcase
          end
        end
      end
      S_MOD: begin
        if (status_i.mod_last) begin
          state_d = S_CHK;
        end
      end
      S_MULX:  state_d = S_MULY;
      S_MULY:  state_d = S_ZFIN;
      S_ZFIN:  state_d = S_CHK;
      S_CHK:   state_d = ld_q ? S_STORE : S_READ;
      S_STORE: state_d = S_IDLE;
      S_READ:  state_d = S_OUT;
      S_OUT:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.capture  = accept;
    cmd_o.mod_step = (state_q == S_MOD);
    cmd_o.mul_x    = (state_q == S_MULX);
    cmd_o.mul_y    = (state_q == S_MULY);
    cmd_o.zoom_fin = (state_q == S_ZFIN);
    cmd_o.check    = (state_q == S_CHK);
    cmd_o.write    = (state_q == S_STORE);
    cmd_o.read     = (state_q == S_READ);
    cmd_o.emit     = (state_q == S_OUT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ld_q    <= 1'b0;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ld_q    <= ld_d;
      busy_q  <= (state_d != S_IDLE);
      done_q  <= (state_q == S_OUT);
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

// ===== rtl/fbsz_dp.sv =====
`timescale 1ns / 1ps
// datapath of the frame blit block: registers, remainder lanes, zoom
// multiplier, frame store and fade; depends on fbsz_pkg
module fbsz_dp
  import fbsz_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fbsz_cmd_t             cmd_i,
  output fbsz_status_t          status_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  func_i,
  input  logic [7:0]            pos_x_i,
  input  logic [7:0]            pos_y_i,
  input  logic [7:0]            in_red_i,
  input  logic [7:0]            in_green_i,
  input  logic [7:0]            in_blue_i,
  output logic [7:0]            out_x_o,
  output logic [7:0]            out_y_o,
  output logic [7:0]            red_o,
  output logic [7:0]            green_o,
  output logic [7:0]            blue_o
);

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned XB    = $clog2(MAX_WIDTH);
  localparam int unsigned YB    = $clog2(MAX_HEIGHT);
  localparam int unsigned RW    = 10;
  localparam int unsigned PW    = 23;

  // configuration registers
  logic [1:0]  mode_q;
  logic [7:0]  width_q;
  logic [6:0]  height_q;
  logic [8:0]  alpha_q;
  logic [6:0]  scroll_q;
  logic [14:0] zinv_q;
  logic [6:0]  zoff_q;

  // item registers
  logic [7:0]          x_q, y_q;
  logic [23:0]         rgb_q;
  logic [CW-1:0]       sx_q, sy_q;
  logic [MOD_BITS-1:0] nx_q, ny_q;
  logic [CNT_W-1:0]    step_q;
  logic                left_q;
  logic [PW-1:0]       prod_q;
  logic [AW-1:0]       addr_q;
  logic                hit_q;
  logic                st_ok_q;
  logic [23:0]         pix_q;
  logic [7:0]          out_x_q, out_y_q, red_q, green_q, blue_q;

  logic [23:0] frame_mem [DEPTH];

  logic [7:0]    w_eff;
  logic [6:0]    h_eff;
  logic [8:0]    al_eff;
  logic [RW-1:0] tx, ty, tx_r, ty_r;
  logic [7:0]    mul_a;
  logic [PW-1:0] mul_p;
  logic [23:0]   pix;
  logic [16:0]   r_sc, g_sc, b_sc;

  // image size saturated to 1..max
  always_comb begin
    if (width_q == 8'd0) begin
      w_eff = 8'd1;
    end else if (width_q > MAX_WIDTH) begin
      w_eff = 8'(MAX_WIDTH);
    end else begin
      w_eff = width_q;
    end
    if (height_q == 7'd0) begin
      h_eff = 7'd1;
    end else if (height_q > MAX_HEIGHT) begin
      h_eff = 7'(MAX_HEIGHT);
    end else begin
      h_eff = height_q;
    end
    al_eff = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
  end

  // restoring remainder step, one numerator bit per lane
  always_comb begin
    tx   = {sx_q[RW-2:0], nx_q[MOD_BITS-1]};
    ty   = {sy_q[RW-2:0], ny_q[MOD_BITS-1]};
    tx_r = (tx >= RW'(w_eff)) ? tx - RW'(w_eff) : tx;
    ty_r = (ty >= RW'(h_eff)) ? ty - RW'(h_eff) : ty;
  end

  // shared zoom multiplier
  assign mul_a = cmd_i.mul_y ? y_q : (x_q - {1'b0, zoff_q});
  assign mul_p = PW'(mul_a) * PW'(zinv_q);

  // fade lanes
  assign pix  = hit_q ? pix_q : 24'd0;
  assign r_sc = 17'(pix[23:16]) * 17'(al_eff);
  assign g_sc = 17'(pix[15:8]) * 17'(al_eff);
  assign b_sc = 17'(pix[7:0]) * 17'(al_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_COPY;
      width_q  <= 8'd96;
      height_q <= 7'd64;
      alpha_q  <= ALPHA_ONE;
      scroll_q <= 7'd0;
      zinv_q   <= 15'd4096;
      zoff_q   <= 7'd0;
      step_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MODE:   mode_q   <= cfg_wdata_i[1:0];
          CFG_WIDTH:  width_q  <= cfg_wdata_i[7:0];
          CFG_HEIGHT: height_q <= cfg_wdata_i[6:0];
          CFG_ALPHA:  alpha_q  <= cfg_wdata_i[8:0];
          CFG_SCROLL: scroll_q <= cfg_wdata_i[6:0];
          CFG_ZINV:   zinv_q   <= cfg_wdata_i[14:0];
          CFG_ZOFF:   zoff_q   <= cfg_wdata_i[6:0];
          default: ;
        endcase
      end
      if (cmd_i.capture) begin
        step_q <= '0;
      end else if (cmd_i.mod_step) begin
        step_q <= step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      x_q    <= pos_x_i;
      y_q    <= pos_y_i;
      rgb_q  <= {in_red_i, in_green_i, in_blue_i};
      left_q <= 1'b0;
      // (x + offset) mod w equals (x + offset mod w) mod w
      nx_q   <= MOD_BITS'(pos_x_i) + MOD_BITS'(scroll_q);
      ny_q   <= MOD_BITS'(pos_y_i);
      if (func_i == FUNC_RENDER && mode_q == MODE_SCROLL) begin
        sx_q <= '0;
        sy_q <= '0;
      end else begin
        sx_q <= CW'(pos_x_i);
        sy_q <= CW'(pos_y_i);
      end
    end
    if (cmd_i.mod_step) begin
      sx_q <= CW'(tx_r);
      sy_q <= CW'(ty_r);
      nx_q <= nx_q << 1;
      ny_q <= ny_q << 1;
    end
    if (cmd_i.mul_x) begin
      left_q <= (x_q < {1'b0, zoff_q});
      prod_q <= mul_p;
    end
    if (cmd_i.mul_y) begin
      sx_q   <= prod_q[PW-1:ZFRAC];
      prod_q <= mul_p;
    end
    if (cmd_i.zoom_fin) begin
      sy_q <= prod_q[PW-1:ZFRAC];
    end
    if (cmd_i.check) begin
      hit_q   <= (sx_q < CW'(w_eff)) && (sy_q < CW'(h_eff)) && !left_q;
      st_ok_q <= (sx_q < MAX_WIDTH) && (sy_q < MAX_HEIGHT);
      addr_q  <= AW'(sy_q[YB-1:0]) * AW'(MAX_WIDTH) + AW'(sx_q[XB-1:0]);
    end
    if (cmd_i.emit) begin
      out_x_q <= x_q;
      out_y_q <= y_q;
      if (mode_q == MODE_FADE) begin
        red_q   <= r_sc[15:8];
        green_q <= g_sc[15:8];
        blue_q  <= b_sc[15:8];
      end else begin
        red_q   <= pix[23:16];
        green_q <= pix[15:8];
        blue_q  <= pix[7:0];
      end
    end
  end

  // frame store, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.write && st_ok_q) begin
      frame_mem[addr_q] <= rgb_q;
    end
    if (cmd_i.read && hit_q) begin
      pix_q <= frame_mem[addr_q];
    end
  end

  assign status_o.mode     = mode_q;
  assign status_o.mod_last = (step_q == CNT_W'(MOD_BITS - 1));

  assign out_x_o = out_x_q;
  assign out_y_o = out_y_q;
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

// ===== rtl/frame_blit_scroll_zoom_fade_top.sv =====
`timescale 1ns / 1ps
// top level of the frame blit block with scroll, zoom and fade
// depends on fbsz_pkg, fbsz_ctrl and fbsz_dp
//
// usage
// - an item is taken at a clock edge with start high and busy low; func_i
//   picks a pixel load (pos and in_* colour) or a render of canvas pixel pos
// - a load writes the frame store and gives no result; it keeps busy high
//   through its check and store steps; the next item can go in after busy drops
// - a render gives one result item: done_o is high for exactly one cycle
//   with out_x_o, out_y_o and the colour; it must be taken in that cycle,
//   the receiver has no way to hold it off
// - render steps after the accept edge: copy and fade check, read and output;
//   zoom first multiplies the column and then the row on one shared 8x15
//   multiplier and then stores the row; scroll first runs the bit-serial remainder,
//   9 steps for column and row lanes side by side
// - busy drops in the cycle done_o is high, so the next item can be taken
//   at the edge that ends the result cycle
// - configuration: cfg_we_i, cfg_idx_i, cfg_wdata_i write one register per
//   edge; the user must write only while the block is idle, it does not enforce it
// - reset puts the registers to copy mode, 96x64 image, unity alpha, no
//   scroll, unity zoom; the frame store is not cleared and must be loaded
//   before any of it is rendered
module frame_blit_scroll_zoom_fade_top
  import fbsz_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic                  func_i,
  input  logic [7:0]            pos_x_i,
  input  logic [7:0]            pos_y_i,
  input  logic [7:0]            in_red_i,
  input  logic [7:0]            in_green_i,
  input  logic [7:0]            in_blue_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output logic                  done_o,
  output logic [7:0]            out_x_o,
  output logic [7:0]            out_y_o,
  output logic [7:0]            red_o,
  output logic [7:0]            green_o,
  output logic [7:0]            blue_o
);

  // command and status between sequencer and datapath
  fbsz_cmd_t    cmd;
  fbsz_status_t status;

  fbsz_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .func_i   (func_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (done_o)
  );

  // frame store, remainder lanes, zoom multiplier and fade live here
  fbsz_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .func_i      (func_i),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .in_red_i    (in_red_i),
    .in_green_i  (in_green_i),
    .in_blue_i   (in_blue_i),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o)
  );

  // a result only shows while the sequencer is back at rest
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("result strobe while busy");

  // a taken item keeps the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) (start && !busy) |=> busy)
    else $error("item taken but block not busy");

  // no two results back to back
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("result strobe held for two cycles");

  // a load never causes a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && func_i == FUNC_LOAD) |=> !done_o ##1 !done_o ##1 !done_o)
    else $error("result after a pixel load");

endmodule
